FILE: rtl/scalar_kalman_adc_filter_top_macros.svh
// assertion macros for the scalar kalman adc filter checker
// expects signals named clk and rst in the scope of each use
`ifndef SCALAR_KALMAN_ADC_FILTER_TOP_MACROS_SVH
`define SCALAR_KALMAN_ADC_FILTER_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SKAF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SKAF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/skaf_pkg.sv
// shared types, widths and constants of the scalar kalman adc filter
// no dependencies; every other rtl module imports this package
package skaf_pkg;

  // channel store
  localparam int CHANNELS = 8;
  localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // field and datapath widths
  localparam int CH_W     = 3;
  localparam int SMP_W    = 16;
  localparam int COV_W    = 32;
  localparam int EST_W    = 32;
  localparam int FRAC_COV = 24;
  localparam int FRAC_EST = 16;
  localparam int QUOT_W   = FRAC_COV;
  localparam int REM_W    = COV_W + 1;
  localparam int ACC_W    = QUOT_W + COV_W;
  localparam int CNT_W    = $clog2(QUOT_W + 1);

  // register reset values and estimate ceiling
  localparam logic [COV_W-1:0] Q_RESET = 32'd5033;
  localparam logic [COV_W-1:0] R_RESET = 32'd1677722;
  localparam logic [EST_W-1:0] EST_MAX = 32'hFFFF_0000;

  // configuration port
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;
  localparam int REG_BIT = 2;
  localparam logic REG_Q = 1'b0;
  localparam logic REG_R = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [SMP_W-1:0] sample;
  } skaf_in_t;

  typedef struct packed {
    logic [CH_W-1:0]  channel_out;
    logic [SMP_W-1:0] filtered;
  } skaf_out_t;

  // one entry of the per-channel store
  typedef struct packed {
    logic [EST_W-1:0] est;
    logic [COV_W-1:0] cov;
  } skaf_chan_t;

  // one quotient bit from the divider to the multipliers
  typedef struct packed {
    logic valid;
    logic last;
    logic qbit;
  } skaf_qbit_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_FINISH
  } skaf_state_t;

endpackage

FILE: rtl/skaf_state.sv
// per-channel estimate and covariance store with registered read
// depends on skaf_pkg; valid bits give the zero reset value
module skaf_state (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [skaf_pkg::CH_AW-1:0] rd_addr,
  output skaf_pkg::skaf_chan_t      rd_data,
  input  logic                      wr_en,
  input  logic [skaf_pkg::CH_AW-1:0] wr_addr,
  input  skaf_pkg::skaf_chan_t      wr_data
);
  import skaf_pkg::*;

  skaf_chan_t          mem [CHANNELS];
  logic [CHANNELS-1:0] valid;
  skaf_chan_t          rd_word;
  logic                rd_valid;

  // entry valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word  <= mem[rd_addr];
      rd_valid <= valid[rd_addr];
    end
  end

  // an entry never written reads as zero
  assign rd_data = rd_valid ? rd_word : '0;

endmodule

FILE: rtl/skaf_div.sv
// radix-2 restoring divider, one gain bit per cycle, msb first
// depends on skaf_pkg; the dividend is prior shifted up by the fraction width
module skaf_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [skaf_pkg::COV_W-1:0] prior,
  input  logic [skaf_pkg::REM_W-1:0] divisor,
  output skaf_pkg::skaf_qbit_t      q_out
);
  import skaf_pkg::*;

  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic [REM_W:0]   trial;
  logic             ge;

  // shift remainder and compare against the divisor
  assign trial = {rem, 1'b0};
  assign ge    = trial >= {1'b0, dsr};

  // bit counter and quotient bit output
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      q_out <= '0;
    end else if (start) begin
      cnt         <= CNT_W'(QUOT_W);
      q_out.valid <= 1'b0;
    end else if (cnt != '0) begin
      q_out.valid <= 1'b1;
      q_out.qbit  <= ge;
      q_out.last  <= (cnt == CNT_W'(1));
      cnt         <= cnt - CNT_W'(1);
    end else begin
      q_out.valid <= 1'b0;
      q_out.last  <= 1'b0;
    end
  end

  // remainder; the prior is always below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, prior};
      dsr <= divisor;
    end else if (cnt != '0) begin
      rem <= ge ? REM_W'(trial - {1'b0, dsr}) : trial[REM_W-1:0];
    end
  end

endmodule

FILE: rtl/skaf_mac.sv
// msb-first serial multiplier: one gain bit per transfer from the divider
// depends on skaf_pkg; accumulator holds the full product of gain and operand
module skaf_mac (
  input  logic                      clk,
  input  logic                      clear,
  input  skaf_pkg::skaf_qbit_t      q_in,
  input  logic [skaf_pkg::COV_W-1:0] operand,
  output logic [skaf_pkg::ACC_W-1:0] acc
);
  import skaf_pkg::*;

  logic [ACC_W-1:0] addend;

  assign addend = q_in.qbit ? ACC_W'(operand) : '0;

  // double and add the selected partial product
  always_ff @(posedge clk) begin
    if (clear) begin
      acc <= '0;
    end else if (q_in.valid) begin
      acc <= {acc[ACC_W-2:0], 1'b0} + addend;
    end
  end

endmodule

FILE: rtl/scalar_kalman_adc_filter_top.sv
// top level of the per-channel scalar kalman filter for adc samples
// depends on skaf_pkg, skaf_state, skaf_div and skaf_mac
//
//   channel   signals                                   direction
//   sample    sample_valid sample_ready sample_data     in
//   result    result_valid result_ready result_data     out
//   config    psel penable pwrite paddr pwdata prdata   apb slave, pready tied high
//
// an item goes from transfer to result through accept, store read, the
// 24-bit gain from the serial divider one bit at a time, and the update.
// the two multiplies run beside the divider on its registered gain bits.
// reset clears the store valid bits and loads the noise registers at once.
// a stalled result holds the update cycle until the output register frees.
module scalar_kalman_adc_filter_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [skaf_pkg::APB_AW-1:0] paddr,
  input  logic [skaf_pkg::APB_DW-1:0] pwdata,
  output logic [skaf_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  input  logic                        sample_valid,
  output logic                        sample_ready,
  input  skaf_pkg::skaf_in_t          sample_data,
  output logic                        result_valid,
  input  logic                        result_ready,
  output skaf_pkg::skaf_out_t         result_data
);
  import skaf_pkg::*;

  skaf_state_t      state;
  skaf_state_t      state_next;
  logic [COV_W-1:0] q_reg;
  logic [COV_W-1:0] r_reg;
  skaf_in_t         item;
  logic [COV_W-1:0] prior;
  logic [EST_W-1:0] mag;
  logic [EST_W-1:0] est;
  logic             neg;

  logic             accept;
  logic             div_start;
  logic             finish;
  logic             ch_ok;
  skaf_chan_t       rd_data;
  skaf_chan_t       wr_data;
  skaf_qbit_t       qbit;
  logic [ACC_W-1:0] acc_corr;
  logic [ACC_W-1:0] acc_cov;

  logic [COV_W:0]   prior_sum;
  logic [COV_W-1:0] prior_sat;
  logic [COV_W-1:0] r_eff;
  logic [REM_W-1:0] divisor;
  logic [EST_W-1:0] target;
  logic             neg_now;
  logic [COV_W-1:0] corr;
  logic [ACC_W-1:0] cov_full;
  logic signed [EST_W+1:0] est_sum;
  logic [EST_W-1:0] est_new;

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_reg <= Q_RESET;
      r_reg <= R_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[REG_BIT])
        REG_Q:   q_reg <= pwdata;
        REG_R:   r_reg <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[REG_BIT])
      REG_Q:   prdata = q_reg;
      REG_R:   prdata = r_reg;
      default: prdata = '0;
    endcase
  end

  // sequencer
  assign accept = sample_valid && sample_ready;
  assign ch_ok  = int'(item.channel) < CHANNELS;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample_ready = 1'b0;
    div_start    = 1'b0;
    finish       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (qbit.valid && qbit.last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!result_valid || result_ready) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // channel store
  skaf_state u_state (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (CH_AW'(sample_data.channel)),
    .rd_data (rd_data),
    .wr_en   (finish && ch_ok),
    .wr_addr (CH_AW'(item.channel)),
    .wr_data (wr_data)
  );

  // prior covariance, divisor and innovation magnitude
  assign prior_sum = {1'b0, rd_data.cov} + {1'b0, q_reg};
  assign prior_sat = prior_sum[COV_W] ? '1 : prior_sum[COV_W-1:0];
  assign r_eff     = (r_reg == '0) ? COV_W'(1) : r_reg;
  assign divisor   = {1'b0, prior_sat} + {1'b0, r_eff};
  assign target    = {item.sample, {FRAC_EST{1'b0}}};
  assign neg_now   = target < rd_data.est;

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= sample_data;
    end
    if (div_start) begin
      prior <= prior_sat;
      est   <= rd_data.est;
      neg   <= neg_now;
      mag   <= neg_now ? rd_data.est - target : target - rd_data.est;
    end
  end

  // gain divider and the two serial multipliers
  skaf_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .prior   (prior_sat),
    .divisor (divisor),
    .q_out   (qbit)
  );

  skaf_mac u_mac_corr (
    .clk     (clk),
    .clear   (div_start),
    .q_in    (qbit),
    .operand (mag),
    .acc     (acc_corr)
  );

  skaf_mac u_mac_cov (
    .clk     (clk),
    .clear   (div_start),
    .q_in    (qbit),
    .operand (prior),
    .acc     (acc_cov)
  );

  // estimate and posterior covariance update
  assign corr     = acc_corr[ACC_W-1 -: COV_W];
  assign cov_full = {prior, {FRAC_COV{1'b0}}} - acc_cov;
  assign est_sum  = neg ? $signed({2'b00, est}) - $signed({2'b00, corr})
                        : $signed({2'b00, est}) + $signed({2'b00, corr});

  always_comb begin
    if (est_sum < 0) begin
      est_new = '0;
    end else if (est_sum > $signed({2'b00, EST_MAX})) begin
      est_new = EST_MAX;
    end else begin
      est_new = est_sum[EST_W-1:0];
    end
  end

  assign wr_data.est = est_new;
  assign wr_data.cov = cov_full[ACC_W-1 -: COV_W];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (finish) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result_data.channel_out <= item.channel;
      result_data.filtered    <= ch_ok ? est_new[EST_W-1 -: SMP_W] : '0;
    end
  end

endmodule

FILE: rtl/skaf_checker.sv
// port-level checker for the scalar kalman adc filter, bound to the top level
// depends on skaf_pkg and scalar_kalman_adc_filter_top_macros.svh
`include "scalar_kalman_adc_filter_top_macros.svh"

module skaf_checker (
  input logic                clk,
  input logic                rst,
  input logic                pready,
  input logic                sample_valid,
  input logic                sample_ready,
  input skaf_pkg::skaf_in_t  sample_data,
  input logic                result_valid,
  input logic                result_ready,
  input skaf_pkg::skaf_out_t result_data
);
  import skaf_pkg::*;

  // a waiting sample keeps its payload until the transfer
  `SKAF_ASSERT_NEXT(a_sample_hold, sample_valid && !sample_ready, sample_valid && $stable(sample_data), "sample changed while waiting")

  // a stalled result keeps its payload
  `SKAF_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_data), "result changed while stalled")

  // the block is busy right after taking a sample
  `SKAF_ASSERT_NEXT(a_busy_after_transfer, sample_valid && sample_ready, !sample_ready, "sample taken back to back")

  // no result can appear the cycle after a transfer
  `SKAF_ASSERT_NEXT(a_no_instant_result, sample_valid && sample_ready && !result_valid, !result_valid, "result too early")

  // a new result is only loaded while an item is in flight
  `SKAF_ASSERT_SAME(a_result_from_work, $rose(result_valid), !$past(sample_ready) && pready, "result without work")

endmodule

bind scalar_kalman_adc_filter_top skaf_checker u_skaf_checker (
  .clk          (clk),
  .rst          (rst),
  .pready       (pready),
  .sample_valid (sample_valid),
  .sample_ready (sample_ready),
  .sample_data  (sample_data),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result_data  (result_data)
);
